/* rtl/binary_trie_max_xor_core_macros.svh */
// Assertion macros for the binary trie max-xor core.
`ifndef BINARY_TRIE_MAX_XOR_CORE_MACROS_SVH
`define BINARY_TRIE_MAX_XOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BTMX_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("btmx assertion failed");

// Next-cycle implication, disabled while reset is low.
`define BTMX_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("btmx assertion failed");

`endif

/* rtl/btmx_pkg.sv */
// Shared constants for the binary trie max-xor core.
`timescale 1ns / 1ps
package btmx_pkg;
    localparam int WIDTH_DEF      = 32;
    localparam int NODE_COUNT_DEF = 4096;
    localparam int DATA_W         = 32;
    localparam int STATUS_W       = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
endpackage

/* rtl/binary_trie_max_xor_core.sv */
// Binary trie max-xor core: node memory and one-level-per-cycle walk sequencer.
//
// Usage:
//   Slave stream: tuser[0] = cmd (0 insert, 1 query), tdata = value (low WIDTH
//   bits used). Master stream: tdata = max_xor, tuser = status (0 ok,
//   1 empty trie on query, 2 node pool full on insert). One result beat per
//   input beat, in order.
//   An item walks the trie one level per cycle through a single-port node
//   memory with registered reads: up to WIDTH levels of walk (an insert
//   that allocates spends the remaining levels writing new nodes, then
//   writes the leaf), then the result is loaded into the output register.
//   A new beat is taken the cycle after the result is loaded, so no beat is
//   taken during a walk; a rejected insert or an empty query skips the walk.
//   The root's links live in flops; every other node is written when it is
//   allocated, so the node memory needs no clearing after reset.
//   Reset (synchronous, active low) empties the trie at once.
//   While the receiver stalls, the result waits in the output register; the
//   next item is accepted and walked, and holds before its result is loaded.
`timescale 1ns / 1ps
`include "binary_trie_max_xor_core_macros.svh"
module binary_trie_max_xor_core #(
    parameter int WIDTH      = btmx_pkg::WIDTH_DEF,
    parameter int NODE_COUNT = btmx_pkg::NODE_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [btmx_pkg::DATA_W-1:0]   i_s_axis_tdata,  // [31:0] value
    input  logic [0:0]                    i_s_axis_tuser,  // [0] cmd
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [btmx_pkg::DATA_W-1:0]   o_m_axis_tdata,  // [31:0] max_xor
    output logic [btmx_pkg::STATUS_W-1:0] o_m_axis_tuser   // [1:0] status
);
    import btmx_pkg::*;

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int NU_W  = $clog2(NODE_COUNT + 1);
    localparam int LVL_W = $clog2(WIDTH);
    localparam int ENT_W = 2 * IDX_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_FILL = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    // entry layout: [IDX_W-1:0] link for bit 0, [ENT_W-1:IDX_W] link for bit 1
    function automatic logic [ENT_W-1:0] set_link(input logic [ENT_W-1:0] ent,
                                                   input logic bsel,
                                                   input logic [IDX_W-1:0] idx);
        logic [ENT_W-1:0] r;
        r = ent;
        if (bsel) r[ENT_W-1:IDX_W] = idx;
        else      r[IDX_W-1:0] = idx;
        return r;
    endfunction

    t_state r_state, n_state;
    logic [WIDTH-1:0]    r_val, n_val;
    logic                r_cmd, n_cmd;
    logic [WIDTH-1:0]    r_res, n_res;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [LVL_W-1:0]    r_lvl, n_lvl;
    logic [IDX_W-1:0]    r_node, n_node;
    logic                r_at_root, n_at_root;
    logic                r_leaf, n_leaf;
    logic [ENT_W-1:0]    r_root, n_root;
    logic [NU_W-1:0]     r_nodes_used, n_nodes_used;
    logic                r_empty, n_empty;
    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_out_data, n_out_data;
    logic [STATUS_W-1:0] r_out_status, n_out_status;

    // node memory
    logic [ENT_W-1:0] r_mem [NODE_COUNT];
    logic [ENT_W-1:0] r_rdata;
    logic             mem_re, mem_we;
    logic [IDX_W-1:0] mem_addr;
    logic [ENT_W-1:0] mem_wdata;

    logic             in_beat, out_free, cur_bit, pool_full;
    logic [ENT_W-1:0] cur_ent;
    logic [IDX_W-1:0] link_same, link_opp, new_idx;
    logic [NU_W-1:0]  free_nodes;

    assign in_beat  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign cur_ent  = r_at_root ? r_root : r_rdata;
    assign cur_bit  = r_val[r_lvl];
    assign link_same = cur_bit ? cur_ent[ENT_W-1:IDX_W] : cur_ent[IDX_W-1:0];
    assign link_opp  = cur_bit ? cur_ent[IDX_W-1:0] : cur_ent[ENT_W-1:IDX_W];
    assign new_idx    = r_nodes_used[IDX_W-1:0];
    assign free_nodes = NU_W'(NODE_COUNT) - r_nodes_used;
    assign pool_full  = free_nodes < NU_W'(WIDTH);

    always_comb begin
        n_state      = r_state;
        n_val        = r_val;
        n_cmd        = r_cmd;
        n_res        = r_res;
        n_status     = r_status;
        n_lvl        = r_lvl;
        n_node       = r_node;
        n_at_root    = r_at_root;
        n_leaf       = r_leaf;
        n_root       = r_root;
        n_nodes_used = r_nodes_used;
        n_empty      = r_empty;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        mem_re       = 1'b0;
        mem_we       = 1'b0;
        mem_addr     = link_same;
        mem_wdata    = '0;

        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_val     = WIDTH'(i_s_axis_tdata);
                    n_cmd     = i_s_axis_tuser[0];
                    n_res     = '0;
                    n_lvl     = LVL_W'(WIDTH - 1);
                    n_node    = '0;
                    n_at_root = 1'b1;
                    n_leaf    = 1'b0;
                    n_status  = ST_OK;
                    n_state   = S_WALK;
                    if (i_s_axis_tuser[0] == CMD_INSERT && pool_full) begin
                        n_status = ST_FULL;
                        n_state  = S_FIN;
                    end else if (i_s_axis_tuser[0] == CMD_QUERY && r_empty) begin
                        n_status = ST_EMPTY;
                        n_state  = S_FIN;
                    end
                end
            end
            S_WALK: begin
                if (r_cmd == CMD_QUERY) begin
                    if (link_opp != '0) begin
                        n_res[r_lvl] = 1'b1;
                        mem_addr     = link_opp;
                    end
                    if (link_opp == '0 && link_same == '0) begin
                        n_state = S_FIN;   // dead end: stop the walk
                    end else if (r_lvl == '0) begin
                        n_state = S_FIN;
                    end else begin
                        mem_re    = 1'b1;
                        n_node    = mem_addr;
                        n_at_root = 1'b0;
                        n_lvl     = r_lvl - 1'b1;
                    end
                end else if (link_same != '0) begin
                    if (r_lvl == '0) begin
                        n_empty = 1'b0;
                        n_state = S_FIN;
                    end else begin
                        mem_re    = 1'b1;
                        n_node    = link_same;
                        n_at_root = 1'b0;
                        n_lvl     = r_lvl - 1'b1;
                    end
                end else begin
                    // missing child: link parent to a fresh node, rest is fill
                    if (r_at_root) begin
                        n_root = set_link(r_root, cur_bit, new_idx);
                    end else begin
                        mem_we    = 1'b1;
                        mem_addr  = r_node;
                        mem_wdata = set_link(r_rdata, cur_bit, new_idx);
                    end
                    n_nodes_used = r_nodes_used + 1'b1;
                    n_node       = new_idx;
                    n_at_root    = 1'b0;
                    if (r_lvl == '0) n_leaf = 1'b1;
                    else             n_lvl  = r_lvl - 1'b1;
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                mem_we   = 1'b1;
                mem_addr = r_node;
                if (r_leaf) begin
                    mem_wdata = '0;
                    n_empty   = 1'b0;
                    n_state   = S_FIN;
                end else begin
                    mem_wdata    = set_link('0, cur_bit, new_idx);
                    n_nodes_used = r_nodes_used + 1'b1;
                    n_node       = new_idx;
                    if (r_lvl == '0) n_leaf = 1'b1;
                    else             n_lvl  = r_lvl - 1'b1;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = DATA_W'(r_res);
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Writes land only during an insert's own walk, at the entry that walk
    // already read or at fresh nodes it never reads, so no read of a just-written entry can overlap.
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wdata;
        if (mem_re) r_rdata <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_root       <= '0;
            r_nodes_used <= NU_W'(1);
            r_empty      <= 1'b1;
            r_out_valid  <= 1'b0;
            r_at_root    <= 1'b1;
            r_leaf       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_root       <= n_root;
            r_nodes_used <= n_nodes_used;
            r_empty      <= n_empty;
            r_out_valid  <= n_out_valid;
            r_at_root    <= n_at_root;
            r_leaf       <= n_leaf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val        <= n_val;
        r_cmd        <= n_cmd;
        r_res        <= n_res;
        r_status     <= n_status;
        r_lvl        <= n_lvl;
        r_node       <= n_node;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_status;

    `BTMX_ASSERT_IMP(a_pool_bound, i_clk, i_rst_n, 1'b1, r_nodes_used <= NU_W'(NODE_COUNT))
    `BTMX_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, in_beat, r_state != S_IDLE)
    `BTMX_ASSERT_IMP(a_fill_insert, i_clk, i_rst_n, r_state == S_FILL, r_cmd == CMD_INSERT)
    `BTMX_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n,
                     o_m_axis_tvalid && o_m_axis_tuser == ST_EMPTY, o_m_axis_tdata == '0)
endmodule

/* sim/binary_trie_max_xor_checker.sv */
// Stream monitor with trie predictor and in-order result scoreboard.
`timescale 1ns / 1ps
module binary_trie_max_xor_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [btmx_pkg::DATA_W-1:0]   i_s_tdata,  // [31:0] value
    input  logic [0:0]                    i_s_tuser,  // [0] cmd
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [btmx_pkg::DATA_W-1:0]   i_m_tdata,  // [31:0] max_xor
    input  logic [btmx_pkg::STATUS_W-1:0] i_m_tuser,  // [1:0] status
    output int                            o_mismatches,
    output int                            o_outstanding
);
    import btmx_pkg::*;

    localparam int WIDTH      = WIDTH_DEF;
    localparam int NODE_COUNT = NODE_COUNT_DEF;
    localparam int REPORT_CAP = 100;

    typedef struct packed {
        logic [DATA_W-1:0]   max_xor;
        logic [STATUS_W-1:0] status;
    } t_xor_result;

    int unsigned trie_links [NODE_COUNT][2];
    int unsigned nodes_alloc;
    logic        trie_is_empty;
    t_xor_result pending_results [$];
    int          beats_in;
    int          beats_out;

    initial o_mismatches = 0;
    assign o_outstanding = beats_in - beats_out;

    task automatic trie_clear();
        int n;
        for (n = 0; n < NODE_COUNT; n++) begin
            trie_links[n][0] = 0;
            trie_links[n][1] = 0;
        end
        nodes_alloc   = 1;
        trie_is_empty = 1'b1;
    endtask

    // Applies one beat to the shadow trie and returns the result it must give.
    task automatic trie_apply(input logic cmd, input logic [DATA_W-1:0] val,
                              output t_xor_result res);
        int unsigned node;
        int unsigned nxt;
        int unsigned want;
        int unsigned same;
        int          lvl;
        logic        b;
        logic        stop;
        res.max_xor = '0;
        res.status  = ST_OK;
        node = 0;
        stop = 1'b0;
        if (cmd == CMD_INSERT) begin
            // rejected whenever a full new path might not fit, duplicates too
            if (nodes_alloc + WIDTH > NODE_COUNT) begin
                res.status = ST_FULL;
            end else begin
                for (lvl = WIDTH - 1; lvl >= 0; lvl--) begin
                    b   = val[lvl];
                    nxt = trie_links[node][b];
                    if (nxt == 0) begin
                        nxt = nodes_alloc;
                        nodes_alloc++;
                        trie_links[nxt][0] = 0;
                        trie_links[nxt][1] = 0;
                        trie_links[node][b] = nxt;
                    end
                    node = nxt;
                end
                trie_is_empty = 1'b0;
            end
        end else if (trie_is_empty) begin
            res.status = ST_EMPTY;
        end else begin
            for (lvl = WIDTH - 1; lvl >= 0 && !stop; lvl--) begin
                b    = val[lvl];
                want = trie_links[node][!b];
                same = trie_links[node][b];
                if (want != 0) begin
                    res.max_xor[lvl] = 1'b1;
                    node = want;
                end else if (same != 0) begin
                    node = same;
                end else begin
                    stop = 1'b1;
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        if (o_mismatches < REPORT_CAP)
            $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_xor_result predicted;
        t_xor_result oldest;
        if (!i_rst_n) begin
            trie_clear();
            pending_results.delete();
            beats_in  <= 0;
            beats_out <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                trie_apply(i_s_tuser[0], i_s_tdata, predicted);
                pending_results.push_back(predicted);
                beats_in <= beats_in + 1;
            end
            if (i_m_tvalid && i_m_tready) begin
                beats_out <= beats_out + 1;
                if (pending_results.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding", i_m_tdata, '0);
                end else begin
                    oldest = pending_results.pop_front();
                    if (i_m_tdata !== oldest.max_xor)
                        report_mismatch("max_xor", i_m_tdata, oldest.max_xor);
                    if (i_m_tuser !== oldest.status)
                        report_mismatch("status", DATA_W'(i_m_tuser),
                                        DATA_W'(oldest.status));
                end
            end
        end
    end
endmodule

/* sim/binary_trie_max_xor_core_test.sv */
// Stimulus, idling control, watchdog and verdict for the trie max-xor core.
`timescale 1ns / 1ps
module binary_trie_max_xor_core_test;
    import btmx_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_BEATS    = 250;
    localparam int FILL_BEATS     = 200;
    localparam int DRAIN_CYCLES   = 40;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata;   // [31:0] value
    logic [0:0]          s_tuser;   // [0] cmd
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [DATA_W-1:0]   m_tdata;   // [31:0] max_xor
    logic [STATUS_W-1:0] m_tuser;   // [1:0] status
    logic                hold_start;
    int                  rx_stall_pct = 0;
    int                  tx_idle_pct;
    int                  mismatches;
    int                  outstanding;
    int                  hold_left = 0;
    int                  quiet_cycles = 0;
    logic [DATA_W-1:0]   cluster_base [4];
    logic [DATA_W-1:0]   stored_values [$];

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    binary_trie_max_xor_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    binary_trie_max_xor_checker chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Receiver: random stalls, or a long hold-off once hold_start pulses.
    always @(posedge clk) begin
        if (hold_start)
            hold_left = HOLD_CYCLES;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("binary_trie_max_xor_core_test: FAIL");
            $finish;
        end
    end

    task automatic send_beat(input logic cmd, input logic [DATA_W-1:0] val);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= val;
        s_tuser[0] <= cmd;
        do @(posedge clk); while (!s_tready);
        if (cmd == CMD_INSERT)
            stored_values.push_back(val);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Mostly values near a few shared prefixes so the pool fills slowly.
    function automatic logic [DATA_W-1:0] pick_value();
        int                r;
        logic [DATA_W-1:0] base;
        r    = $urandom_range(99);
        base = cluster_base[$urandom_range(3)];
        if (r < 55)
            return {base[DATA_W-1:8], 8'($urandom)};
        if (r < 70 && stored_values.size() > 0)
            return stored_values[$urandom_range(stored_values.size() - 1)];
        if (r < 85)
            return ~{base[DATA_W-1:8], 8'($urandom)};
        return $urandom;
    endfunction

    task automatic send_random();
        send_beat(1'($urandom_range(1)), pick_value());
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct <= rx_pct;
    endtask

    initial begin
        int k;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        hold_start  = 1'b0;
        tx_idle_pct = 0;
        for (k = 0; k < 4; k++)
            cluster_base[k] = $urandom;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty trie, extremes, duplicates
        send_beat(CMD_QUERY,  32'h0000_0000);
        send_beat(CMD_QUERY,  32'hFFFF_FFFF);
        send_beat(CMD_INSERT, 32'h0000_0000);
        send_beat(CMD_QUERY,  32'h0000_0000);
        send_beat(CMD_QUERY,  32'hFFFF_FFFF);
        send_beat(CMD_INSERT, 32'h0000_0000);
        send_beat(CMD_INSERT, 32'hFFFF_FFFF);
        send_beat(CMD_QUERY,  32'h0000_0000);
        send_beat(CMD_QUERY,  32'hAAAA_AAAA);
        send_beat(CMD_INSERT, 32'h8000_0000);
        send_beat(CMD_INSERT, 32'h0000_0001);
        send_beat(CMD_QUERY,  32'h7FFF_FFFF);
        send_beat(CMD_QUERY,  32'h5555_5555);
        send_beat(CMD_INSERT, 32'h1234_5678);
        send_beat(CMD_QUERY,  32'h1234_5678);
        send_beat(CMD_INSERT, 32'hFFFF_FFFE);
        send_beat(CMD_QUERY,  32'h0000_0001);
        send_beat(CMD_INSERT, 32'hFFFF_FFFF);
        send_beat(CMD_QUERY,  32'h8000_0000);
        wait_drained();

        // receiver holds off while the sender keeps offering beats
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        repeat (12) send_random();
        wait_drained();

        set_idling(0, 0);
        repeat (PHASE_BEATS) send_random();
        wait_drained();
        set_idling(61, 0);
        repeat (PHASE_BEATS) send_random();
        wait_drained();
        set_idling(0, 61);
        repeat (PHASE_BEATS) send_random();
        wait_drained();
        set_idling(35, 35);
        repeat (PHASE_BEATS) send_random();
        wait_drained();

        // scattered inserts exhaust the node pool; later inserts are rejected
        repeat (FILL_BEATS) begin
            if ($urandom_range(3) == 0)
                send_beat(CMD_QUERY, $urandom);
            else if ($urandom_range(7) == 0)
                send_random();
            else
                send_beat(CMD_INSERT, $urandom);
        end
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("binary_trie_max_xor_core_test: PASS");
        else
            $display("binary_trie_max_xor_core_test: FAIL");
        $finish;
    end
endmodule
